>>> design/pwt_pkg.sv
// pwt_pkg: shared types and constants for the pedal and wheel tachometer
// payload structs for both channels, register indexes, reset values, divider bus
// no dependencies
`default_nettype none

package pwt_pkg;

    localparam int DIV_BITS = 24;
    localparam int CNT_BITS = $clog2(DIV_BITS);
    localparam int NUM_BITS = 24;
    localparam int TMO_BITS = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PEDAL_NUM = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WHEEL_NUM = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEDAL_TMO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WHEEL_TMO = 2'd3;

    localparam logic [NUM_BITS-1:0] PEDAL_NUM_RST = 24'd25000;
    localparam logic [NUM_BITS-1:0] WHEEL_NUM_RST = 24'd600000;
    localparam logic [TMO_BITS-1:0] PEDAL_TMO_RST = 16'd1500;
    localparam logic [TMO_BITS-1:0] WHEEL_TMO_RST = 16'd50000;

    typedef struct packed {
        logic pedal_a;
        logic pedal_b;
        logic wheel_pulse;
    } item_t;

    typedef struct packed {
        logic [7:0]  cadence_rpm;
        logic [7:0]  pedal_pulse_count;
        logic        pedaling_forward;
        logic        pedaling_backward;
        logic [15:0] wheel_ticks_per_minute;
        logic        wheel_moving;
    } result_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> design/pwt_div.sv
// pwt_div: restoring divider, one quotient bit per cycle
// depends on pwt_pkg for the request and response structs
`default_nettype none

module pwt_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pwt_pkg::div_req_t req,
    output pwt_pkg::div_rsp_t   rsp
);
    import pwt_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0] quot_reg, quot_next;
    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] den_reg, den_next;

    logic [DIV_BITS:0]   trial;
    logic [DIV_BITS+1:0] diff;

    always_comb
    begin
        // quot_reg holds the remaining dividend bits in its top and the quotient below
        trial     = {rem_reg, quot_reg[DIV_BITS-1]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DIV_BITS - 1);
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (diff[DIV_BITS+1])
            begin
                rem_next  = trial[DIV_BITS-1:0];
                quot_next = {quot_reg[DIV_BITS-2:0], 1'b0};
            end
            else
            begin
                rem_next  = diff[DIV_BITS-1:0];
                quot_next = {quot_reg[DIV_BITS-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg && !done_reg)
        else $error("divider started while busy");

    a_busy_length: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> ##1 busy_reg)
        else $error("divider ran for fewer than two steps");

endmodule

`default_nettype wire

>>> design/pedal_and_wheel_tachometer.sv
// pedal_and_wheel_tachometer: period based cadence and wheel rate
// a tick with no new rate goes straight to the result; a new rate runs a division first,
// a tick with both runs pedal then wheel on the shared 24-step divider (one quotient bit per cycle)
// one tick in flight at a time; the next is taken as soon as the result is registered
// reset clears all period, pulse and rate state and loads the register defaults
// depends on pwt_pkg and pwt_div
`default_nettype none

module pedal_and_wheel_tachometer #(
    parameter int PERIOD_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    output logic                                      item_stall,
    input  wire pwt_pkg::item_t                       item,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output pwt_pkg::result_t                          result,
    input  wire logic                                 cfg_we,
    input  wire logic [pwt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [pwt_pkg::NUM_BITS-1:0]         cfg_data
);
    import pwt_pkg::*;

    localparam int CMP_BITS = (PERIOD_BITS > TMO_BITS) ? PERIOD_BITS : TMO_BITS;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PEDAL = 4'b0010,
        S_WHEEL = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [NUM_BITS-1:0]    pedal_num_reg, wheel_num_reg;
    logic [TMO_BITS-1:0]    pedal_tmo_reg, wheel_tmo_reg;

    logic [PERIOD_BITS-1:0] pedal_period_reg, pedal_period_next;
    logic                   pedal_prev_reg, pedal_prev_next;
    logic [7:0]             pedal_pulses_reg, pedal_pulses_next;
    logic                   pedal_back_reg, pedal_back_next;
    logic [7:0]             cadence_reg, cadence_next;
    logic [PERIOD_BITS-1:0] wheel_period_reg, wheel_period_next;
    logic                   wheel_prev_reg, wheel_prev_next;
    logic [15:0]            wheel_rate_reg, wheel_rate_next;

    logic                   wheel_pend_reg, wheel_pend_next;
    logic                   div_start_reg, div_start_next;
    logic [PERIOD_BITS-1:0] pedal_den_reg, pedal_den_next;
    logic [PERIOD_BITS-1:0] wheel_den_reg, wheel_den_next;

    logic                   result_valid_reg, result_valid_next;
    result_t                result_reg, result_next;

    logic                   accept;
    logic                   pedal_edge, wheel_edge;
    logic                   pedal_div, wheel_div;
    logic [PERIOD_BITS-1:0] pedal_inc, wheel_inc;

    div_req_t div_req;
    div_rsp_t div_rsp;

    pwt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign div_req.start = div_start_reg;
    assign div_req.num   = (state_reg == S_WHEEL) ? wheel_num_reg : pedal_num_reg;
    assign div_req.den   = (state_reg == S_WHEEL) ? DIV_BITS'(wheel_den_reg)
                                                  : DIV_BITS'(pedal_den_reg);

    always_comb
    begin
        pedal_edge = item.pedal_a && !pedal_prev_reg;
        wheel_edge = item.wheel_pulse && !wheel_prev_reg;
        pedal_inc  = (pedal_period_reg == PERIOD_MAX) ? PERIOD_MAX : pedal_period_reg + 1'b1;
        wheel_inc  = (wheel_period_reg == PERIOD_MAX) ? PERIOD_MAX : wheel_period_reg + 1'b1;
        pedal_div  = pedal_edge && (pedal_period_reg != '0);
        wheel_div  = wheel_edge && (wheel_period_reg != '0);

        state_next        = state_reg;
        pedal_period_next = pedal_period_reg;
        pedal_prev_next   = pedal_prev_reg;
        pedal_pulses_next = pedal_pulses_reg;
        pedal_back_next   = pedal_back_reg;
        cadence_next      = cadence_reg;
        wheel_period_next = wheel_period_reg;
        wheel_prev_next   = wheel_prev_reg;
        wheel_rate_next   = wheel_rate_reg;
        wheel_pend_next   = wheel_pend_reg;
        div_start_next    = 1'b0;
        pedal_den_next    = pedal_den_reg;
        wheel_den_next    = wheel_den_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // pedal channel
                    if (pedal_edge)
                    begin
                        pedal_pulses_next = pedal_pulses_reg + 1'b1;
                        pedal_back_next   = item.pedal_b;
                        if (pedal_div)
                        begin
                            pedal_den_next    = pedal_period_reg;
                            pedal_period_next = '0;
                        end
                    end
                    else
                    begin
                        pedal_period_next = pedal_inc;
                        if (cadence_reg != '0 &&
                            CMP_BITS'(pedal_inc) > CMP_BITS'(pedal_tmo_reg))
                        begin
                            cadence_next      = '0;
                            pedal_pulses_next = '0;
                            pedal_back_next   = 1'b0;
                        end
                    end
                    pedal_prev_next = item.pedal_a;

                    // wheel channel
                    if (wheel_edge)
                    begin
                        if (wheel_div)
                        begin
                            wheel_den_next    = wheel_period_reg;
                            wheel_period_next = '0;
                        end
                    end
                    else
                    begin
                        wheel_period_next = wheel_inc;
                        if (wheel_rate_reg != '0 &&
                            CMP_BITS'(wheel_inc) > CMP_BITS'(wheel_tmo_reg))
                        begin
                            wheel_rate_next = '0;
                        end
                    end
                    wheel_prev_next = item.wheel_pulse;

                    wheel_pend_next = wheel_div;
                    if (pedal_div)
                    begin
                        state_next     = S_PEDAL;
                        div_start_next = 1'b1;
                    end
                    else if (wheel_div)
                    begin
                        state_next     = S_WHEEL;
                        div_start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PEDAL:
            begin
                if (div_rsp.done)
                begin
                    cadence_next = (|div_rsp.quot[DIV_BITS-1:8]) ? 8'hFF : div_rsp.quot[7:0];
                    if (wheel_pend_reg)
                    begin
                        state_next     = S_WHEEL;
                        div_start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WHEEL:
            begin
                if (div_rsp.done)
                begin
                    wheel_rate_next = (|div_rsp.quot[DIV_BITS-1:16]) ? 16'hFFFF
                                                                     : div_rsp.quot[15:0];
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next                  = 1'b1;
                    result_next.cadence_rpm            = cadence_reg;
                    result_next.pedal_pulse_count      = pedal_pulses_reg;
                    result_next.pedaling_forward       = (cadence_reg != '0) && !pedal_back_reg;
                    result_next.pedaling_backward      = (cadence_reg != '0) && pedal_back_reg;
                    result_next.wheel_ticks_per_minute = wheel_rate_reg;
                    result_next.wheel_moving           = (wheel_rate_reg != '0);
                    state_next                         = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pedal_period_reg <= '0;
            pedal_prev_reg   <= 1'b0;
            pedal_pulses_reg <= '0;
            pedal_back_reg   <= 1'b0;
            cadence_reg      <= '0;
            wheel_period_reg <= '0;
            wheel_prev_reg   <= 1'b0;
            wheel_rate_reg   <= '0;
            wheel_pend_reg   <= 1'b0;
            div_start_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pedal_period_reg <= pedal_period_next;
            pedal_prev_reg   <= pedal_prev_next;
            pedal_pulses_reg <= pedal_pulses_next;
            pedal_back_reg   <= pedal_back_next;
            cadence_reg      <= cadence_next;
            wheel_period_reg <= wheel_period_next;
            wheel_prev_reg   <= wheel_prev_next;
            wheel_rate_reg   <= wheel_rate_next;
            wheel_pend_reg   <= wheel_pend_next;
            div_start_reg    <= div_start_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pedal_num_reg <= PEDAL_NUM_RST;
            wheel_num_reg <= WHEEL_NUM_RST;
            pedal_tmo_reg <= PEDAL_TMO_RST;
            wheel_tmo_reg <= WHEEL_TMO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PEDAL_NUM: pedal_num_reg <= cfg_data;
                CFG_WHEEL_NUM: wheel_num_reg <= cfg_data;
                CFG_PEDAL_TMO: pedal_tmo_reg <= cfg_data[TMO_BITS-1:0];
                CFG_WHEEL_TMO: wheel_tmo_reg <= cfg_data[TMO_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pedal_den_reg <= pedal_den_next;
        wheel_den_reg <= wheel_den_next;
        result_reg    <= result_next;
    end

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_PEDAL || state_reg == S_WHEEL))
        else $error("divider finished outside a division state");

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_rsp.busy && !div_start_reg)
        else $error("divider active while sequencer idle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result registered outside the done state");

    a_period_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PEDAL) |-> (pedal_period_reg == '0))
        else $error("pedal period not cleared for a new cadence");

endmodule

`default_nettype wire

>>> test/testbench.sv
// testbench for pedal_and_wheel_tachometer: directed edge cases, random sensor waveforms
// a scoreboard class predicts each reading from the accepted ticks and checks results in order
// depends on pwt_pkg and the pedal_and_wheel_tachometer rtl

module testbench;
    import pwt_pkg::*;

    localparam int GAP_BITS = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_PHASES = 6;
    localparam int TICKS_PER_PHASE = 36;
    localparam int STOP_TICKS = 30;

    class tach_scoreboard;
        logic [NUM_BITS-1:0] crank_num;
        logic [NUM_BITS-1:0] wheel_num;
        logic [TMO_BITS-1:0] crank_limit;
        logic [TMO_BITS-1:0] wheel_limit;
        logic [GAP_BITS-1:0] crank_gap;
        logic [GAP_BITS-1:0] wheel_gap;
        logic                crank_level;
        logic                wheel_level;
        logic                crank_reverse;
        logic [15:0]         crank_count;
        logic [7:0]          rpm;
        logic [15:0]         wheel_tpm;
        result_t             pending_readings[$];
        int                  errors;
        int                  checked;

        function new();
            crank_num = PEDAL_NUM_RST;
            wheel_num = WHEEL_NUM_RST;
            crank_limit = PEDAL_TMO_RST;
            wheel_limit = WHEEL_TMO_RST;
            crank_gap = '0;
            wheel_gap = '0;
            crank_level = 1'b0;
            wheel_level = 1'b0;
            crank_reverse = 1'b0;
            crank_count = '0;
            rpm = '0;
            wheel_tpm = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void note_setting(logic [CFG_IDX_BITS-1:0] idx, logic [NUM_BITS-1:0] data);
            case (idx)
                CFG_PEDAL_NUM: crank_num = data;
                CFG_WHEEL_NUM: wheel_num = data;
                CFG_PEDAL_TMO: crank_limit = data[TMO_BITS-1:0];
                CFG_WHEEL_TMO: wheel_limit = data[TMO_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(item_t t);
            result_t             r;
            logic [NUM_BITS-1:0] q;
            if (t.pedal_a && !crank_level) begin
                crank_count = crank_count + 16'd1;
                crank_reverse = t.pedal_b;
                // first edge after a clear leaves the rate alone
                if (crank_gap != 0) begin
                    q = crank_num / crank_gap;
                    rpm = (q > 255) ? 8'd255 : q[7:0];
                    crank_gap = '0;
                end
            end
            else begin
                if (crank_gap != {GAP_BITS{1'b1}})
                    crank_gap = crank_gap + 1'b1;
                if (rpm != 0 && crank_gap > crank_limit) begin
                    rpm = '0;
                    crank_count = '0;
                    crank_reverse = 1'b0;
                end
            end
            crank_level = t.pedal_a;

            if (t.wheel_pulse && !wheel_level) begin
                if (wheel_gap != 0) begin
                    q = wheel_num / wheel_gap;
                    wheel_tpm = (q > 65535) ? 16'hFFFF : q[15:0];
                    wheel_gap = '0;
                end
            end
            else begin
                if (wheel_gap != {GAP_BITS{1'b1}})
                    wheel_gap = wheel_gap + 1'b1;
                if (wheel_tpm != 0 && wheel_gap > wheel_limit)
                    wheel_tpm = '0;
            end
            wheel_level = t.wheel_pulse;

            r.cadence_rpm = rpm;
            r.pedal_pulse_count = crank_count[7:0];
            r.pedaling_forward = (rpm != 0) && !crank_reverse;
            r.pedaling_backward = (rpm != 0) && crank_reverse;
            r.wheel_ticks_per_minute = wheel_tpm;
            r.wheel_moving = (wheel_tpm != 0);
            pending_readings.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_reading(result_t got);
            result_t want;
            if (pending_readings.size() == 0) begin
                report($sformatf("reading %0d arrived with nothing pending", checked));
            end
            else begin
                want = pending_readings.pop_front();
                if (got.cadence_rpm !== want.cadence_rpm)
                    report($sformatf("reading %0d cadence_rpm %0d, want %0d",
                                     checked, got.cadence_rpm, want.cadence_rpm));
                if (got.pedal_pulse_count !== want.pedal_pulse_count)
                    report($sformatf("reading %0d pedal_pulse_count %0d, want %0d",
                                     checked, got.pedal_pulse_count, want.pedal_pulse_count));
                if (got.pedaling_forward !== want.pedaling_forward)
                    report($sformatf("reading %0d pedaling_forward %b, want %b",
                                     checked, got.pedaling_forward, want.pedaling_forward));
                if (got.pedaling_backward !== want.pedaling_backward)
                    report($sformatf("reading %0d pedaling_backward %b, want %b",
                                     checked, got.pedaling_backward, want.pedaling_backward));
                if (got.wheel_ticks_per_minute !== want.wheel_ticks_per_minute)
                    report($sformatf("reading %0d wheel_ticks_per_minute %0d, want %0d", checked,
                                     got.wheel_ticks_per_minute, want.wheel_ticks_per_minute));
                if (got.wheel_moving !== want.wheel_moving)
                    report($sformatf("reading %0d wheel_moving %b, want %b",
                                     checked, got.wheel_moving, want.wheel_moving));
            end
            checked++;
        endtask
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    item_valid = 1'b0;
    logic                    item_stall;
    item_t                   item = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    result_t                 result;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [NUM_BITS-1:0]     cfg_data = '0;

    tach_scoreboard board;
    bit   quiet = 1'b0;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    int   cycles = 0;
    int   ticks_sent = 0;
    int   settings_used = 0;
    logic crank_drv = 1'b0;
    logic wheel_drv = 1'b0;

    pedal_and_wheel_tachometer #(
        .PERIOD_BITS(GAP_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result side: check each transaction, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                board.check_reading(result);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < 13);
        end
    end

    task automatic send_tick(input logic a, input logic b, input logic w);
        item_t t;
        t.pedal_a = a;
        t.pedal_b = b;
        t.wheel_pulse = w;
        if (!quiet && $urandom_range(99) < 13)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= t;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        board.note_tick(t);
        ticks_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (board.pending_readings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [NUM_BITS-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        board.note_setting(idx, v);
    endtask

    task automatic apply_settings(input logic [NUM_BITS-1:0] pn, input logic [NUM_BITS-1:0] wn,
                                  input logic [NUM_BITS-1:0] pt, input logic [NUM_BITS-1:0] wt);
        write_reg(CFG_PEDAL_NUM, pn);
        write_reg(CFG_WHEEL_NUM, wn);
        write_reg(CFG_PEDAL_TMO, pt);
        write_reg(CFG_WHEEL_TMO, wt);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly square waves on both sensors, some stopped stretches, some noise
    task automatic run_random(input int n_ticks);
        int   kind;
        int   len;
        int   ped_half;
        int   wheel_half;
        int   ped_cnt;
        int   wheel_cnt;
        int   done_ticks;
        logic dir;
        done_ticks = 0;
        ped_cnt = 0;
        wheel_cnt = 0;
        while (done_ticks < n_ticks)
        begin
            kind = $urandom_range(99);
            len = $urandom_range(40, 10);
            ped_half = $urandom_range(12, 1);
            wheel_half = $urandom_range(16, 1);
            dir = 1'($urandom_range(1));
            if (kind >= 70 && kind < 85)
                len = $urandom_range(80, 5);
            for (int k = 0; k < len; k++)
            begin
                if (kind < 70)
                begin
                    ped_cnt = ped_cnt + 1;
                    if (ped_cnt >= ped_half)
                    begin
                        ped_cnt = 0;
                        crank_drv = !crank_drv;
                    end
                    wheel_cnt = wheel_cnt + 1;
                    if (wheel_cnt >= wheel_half)
                    begin
                        wheel_cnt = 0;
                        wheel_drv = !wheel_drv;
                    end
                    send_tick(crank_drv, dir ^ ($urandom_range(15) == 0), wheel_drv);
                end
                else if (kind < 85)
                    send_tick(crank_drv, 1'($urandom_range(1)), wheel_drv);
                else
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            end
            done_ticks += len;
        end
    endtask

    initial
    begin
        logic [NUM_BITS-1:0] pn;
        logic [NUM_BITS-1:0] wn;
        logic [NUM_BITS-1:0] pt;
        logic [NUM_BITS-1:0] wt;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: first edges with zero period, then saturated quotients
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        drain();

        // zero numerators: rates read stopped, pulses keep counting
        apply_settings(24'd0, 24'd0, 24'd2, 24'd2);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        drain();

        // largest numerators with zero timeouts: rate set, then cleared on the next tick
        apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            if (p == 0)
            begin
                pn = 24'd1;
                wn = 24'd1;
            end
            else if ($urandom_range(3) == 0)
            begin
                pn = NUM_BITS'($urandom_range(24'hFFFFFF));
                wn = NUM_BITS'($urandom_range(24'hFFFFFF));
            end
            else
            begin
                pn = NUM_BITS'($urandom_range(3000, 40));
                wn = NUM_BITS'($urandom_range(1500000, 50));
            end
            // upper data bits are junk for the 16-bit timeouts
            pt = NUM_BITS'(($urandom & 32'hFF0000) | $urandom_range(60, 3));
            wt = NUM_BITS'(($urandom & 32'hFF0000) | $urandom_range(60, 3));
            if (p == 5)
                wt = NUM_BITS'($urandom_range(24'hFFFFFF));
            apply_settings(pn, wn, pt, wt);
            quiet = (p == 4);
            if (p == 2)
                hold_req = 1'b1;
            run_random(TICKS_PER_PHASE);
        end
        drain();

        // largest timeouts: pulse count past 255, then a stretch with no edges
        quiet = 1'b1;
        apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hA5FFFF, 24'h5AFFFF);
        repeat (258)
        begin
            send_tick(1'b0, 1'b0, 1'b0);
            send_tick(1'b1, 1'($urandom_range(1)), 1'b1);
        end
        repeat (STOP_TICKS) send_tick(1'b0, 1'($urandom_range(1)), 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        quiet = 1'b0;

        drain();
        repeat (56) @(posedge clk);
        if (board.pending_readings.size() != 0)
            board.report($sformatf("%0d readings never arrived", board.pending_readings.size()));

        $display("summary: %0d ticks over %0d register settings, %0d readings checked",
                 ticks_sent, settings_used, board.checked);
        $display("summary: edge cases, random sensor waveforms, long receiver hold, pulse wrap");
        if (board.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
